/* rtl/aabb_body_integrate_and_resolve_macros.svh */
// Assertion macros for the box body integrator and collision resolver.
// Used by the top level; expects clk_i and rst_ni in the enclosing scope.
`ifndef AABB_BODY_INTEGRATE_AND_RESOLVE_MACROS_SVH
`define AABB_BODY_INTEGRATE_AND_RESOLVE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ABIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Plain invariant checked at every clock edge outside reset.
`define ABIR_ASSERT_ALW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

/* rtl/abir_pkg.sv */
// Shared types and constants for the box body integrator and resolver.
// Used by the controller, the datapath and the top level; no dependencies.
package abir_pkg;

  localparam int unsigned CfgW = 32;

  localparam logic [30:0] HALF_RESET = 31'd524288;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESOLVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_GRAVITY_X = 2'd0,
    CFG_GRAVITY_Y = 2'd1,
    CFG_HALF_W    = 2'd2,
    CFG_HALF_H    = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_GX,
    ST_ADD_VX,
    ST_ADD_VY,
    ST_ADD_PX,
    ST_ADD_PY,
    ST_OVERLAP,
    ST_PUSH,
    ST_FINISH
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MUL_GX,
    MUL_GY,
    MUL_VX,
    MUL_VY
  } mul_sel_e;

  typedef enum logic [1:0] {
    ADD_VX,
    ADD_VY,
    ADD_PX,
    ADD_PY
  } add_sel_e;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     add_en;
    add_sel_e add_sel;
    logic     ov_en;
    logic     push_en;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_op;
    logic       out_ready;
  } ctrl_status_t;

endpackage

/* rtl/abir_if.sv */
// Channel interfaces of the box body block: input items and result items.
// Each carries valid, ready and the payload; no dependencies.
interface abir_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] load_x;
  logic signed [31:0] load_y;
  logic [16:0]        delta_t;
  logic signed [31:0] other_cx;
  logic signed [31:0] other_cy;
  logic [30:0]        other_hw;
  logic [30:0]        other_hh;
  logic signed [31:0] old_x;
  logic signed [31:0] old_y;

  modport source (
    output valid, op, load_x, load_y, delta_t, other_cx, other_cy,
    output other_hw, other_hh, old_x, old_y,
    input  ready
  );
  modport sink (
    input  valid, op, load_x, load_y, delta_t, other_cx, other_cy,
    input  other_hw, other_hh, old_x, old_y,
    output ready
  );
endinterface

interface abir_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] body_x;
  logic signed [31:0] body_y;
  logic signed [31:0] speed_x;
  logic signed [31:0] speed_y;
  logic               hit_left;
  logic               hit_right;
  logic               hit_bottom;
  logic               hit_top;

  modport source (
    output valid, body_x, body_y, speed_x, speed_y,
    output hit_left, hit_right, hit_bottom, hit_top,
    input  ready
  );
  modport sink (
    input  valid, body_x, body_y, speed_x, speed_y,
    input  hit_left, hit_right, hit_bottom, hit_top,
    output ready
  );
endinterface

/* rtl/aabb_body_integrate_and_resolve.sv */
// Top level of the box body integrator and collision resolver.
// Depends on abir_pkg, abir_if, abir_ctrl, abir_dp and the assertion macros.
//
// Usage: items arrive on in_ch (valid/ready). Each accepted transaction
// yields exactly one result transaction on out_ch carrying the body state
// after the item. Configuration (gravity, half extents) is written through
// cfg_we_i, cfg_idx_i and cfg_data_i while the block is idle.
// The block works on one item at a time. A load and the unused op go straight
// to the result step. A tick runs four products through one shared 32x18
// multiplier, each followed by a saturating add, with each later product
// overlapped with the previous add. A resolve computes the overlap terms,
// then the overlap depths, then applies the push. A new item is taken only
// after the result of the last one is loaded, as in_ch.ready returns the
// cycle after the result is loaded.
// The result sits in its own register, so a new item is accepted while the
// previous result is still waiting; if the receiver stalls, the finished
// item holds in its last step until the result register frees up.
// Reset clears the body state, sets gravity to zero and the half extents
// to 8.0, and empties the result register.
`include "aabb_body_integrate_and_resolve_macros.svh"

module aabb_body_integrate_and_resolve (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  abir_in_if.sink                   in_ch,
  abir_out_if.source                out_ch,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [abir_pkg::CfgW-1:0] cfg_data_i
);
  import abir_pkg::*;

  dp_cmd_t      cmd;
  ctrl_status_t status;
  logic [3:0]   hits;

  assign status.in_valid  = in_ch.valid;
  assign status.in_op     = in_ch.op;
  assign status.out_ready = out_ch.ready;

  abir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid)
  );

  abir_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .op_i       (in_ch.op),
    .load_x_i   (in_ch.load_x),
    .load_y_i   (in_ch.load_y),
    .delta_t_i  (in_ch.delta_t),
    .other_cx_i (in_ch.other_cx),
    .other_cy_i (in_ch.other_cy),
    .other_hw_i (in_ch.other_hw),
    .other_hh_i (in_ch.other_hh),
    .old_x_i    (in_ch.old_x),
    .old_y_i    (in_ch.old_y),
    .body_x_o   (out_ch.body_x),
    .body_y_o   (out_ch.body_y),
    .speed_x_o  (out_ch.speed_x),
    .speed_y_o  (out_ch.speed_y),
    .hits_o     (hits)
  );

  assign out_ch.hit_left   = hits[0];
  assign out_ch.hit_right  = hits[1];
  assign out_ch.hit_bottom = hits[2];
  assign out_ch.hit_top    = hits[3];

  `ABIR_ASSERT_ALW(a_cmd_exclusive, $onehot0({cmd.capture, cmd.add_en, cmd.ov_en, cmd.push_en}), "datapath steps overlap")
  `ABIR_ASSERT_IMP(a_no_overwrite, cmd.out_load, (!out_ch.valid || out_ch.ready), "result overwritten before transaction")
  `ABIR_ASSERT_IMP(a_busy_after_accept, in_ch.valid && in_ch.ready, ##1 !in_ch.ready, "input accepted while busy")
  `ABIR_ASSERT_IMP(a_tick_length, in_ch.valid && in_ch.ready && in_ch.op == OP_TICK, ##5 !in_ch.ready, "tick finished early")

endmodule

/* rtl/abir_ctrl.sv */
// Controller of the box body block: sequences load, tick and resolve steps.
// Depends on abir_pkg for the state, command and status types.
module abir_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  abir_pkg::ctrl_status_t status_i,
  output abir_pkg::dp_cmd_t      cmd_o,
  output logic                   in_ready_o,
  output logic                   out_valid_o
);
  import abir_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid) begin
          case (status_i.in_op)
            OP_TICK:    state_d = ST_MUL_GX;
            OP_RESOLVE: state_d = ST_OVERLAP;
            default:    state_d = ST_FINISH;
          endcase
        end
      end
      ST_MUL_GX:  state_d = ST_ADD_VX;
      ST_ADD_VX:  state_d = ST_ADD_VY;
      ST_ADD_VY:  state_d = ST_ADD_PX;
      ST_ADD_PX:  state_d = ST_ADD_PY;
      ST_ADD_PY:  state_d = ST_FINISH;
      ST_OVERLAP: state_d = ST_PUSH;
      ST_PUSH:    state_d = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid_q || status_i.out_ready) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_GX;
    cmd_o.add_sel = ADD_VX;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = status_i.in_valid;
      end
      ST_MUL_GX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GX;
      end
      ST_ADD_VX: begin
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = ADD_VX;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GY;
      end
      ST_ADD_VY: begin
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = ADD_VY;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_VX;
      end
      ST_ADD_PX: begin
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = ADD_PX;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_VY;
      end
      ST_ADD_PY: begin
        cmd_o.add_en  = 1'b1;
        cmd_o.add_sel = ADD_PY;
      end
      ST_OVERLAP: cmd_o.ov_en   = 1'b1;
      ST_PUSH:    cmd_o.push_en = 1'b1;
      ST_FINISH:  cmd_o.out_load = !out_valid_q || status_i.out_ready;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (status_i.out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/abir_dp.sv */
// Datapath of the box body block: configuration, body state, shared multiplier,
// overlap evaluation and the result register. Depends on abir_pkg.
module abir_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  abir_pkg::dp_cmd_t             cmd_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [abir_pkg::CfgW-1:0]     cfg_data_i,
  input  logic [1:0]                    op_i,
  input  logic signed [31:0]            load_x_i,
  input  logic signed [31:0]            load_y_i,
  input  logic [16:0]                   delta_t_i,
  input  logic signed [31:0]            other_cx_i,
  input  logic signed [31:0]            other_cy_i,
  input  logic [30:0]                   other_hw_i,
  input  logic [30:0]                   other_hh_i,
  input  logic signed [31:0]            old_x_i,
  input  logic signed [31:0]            old_y_i,
  output logic signed [31:0]            body_x_o,
  output logic signed [31:0]            body_y_o,
  output logic signed [31:0]            speed_x_o,
  output logic signed [31:0]            speed_y_o,
  output logic [3:0]                    hits_o
);
  import abir_pkg::*;

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      r = v[31:0];
    end else if (v[35]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic signed [33:0] overlap(input logic [31:0] s,
                                                 input logic signed [32:0] d);
    logic signed [33:0] a;
    logic signed [33:0] b;
    a = $signed({2'b00, s}) + 34'(d);
    b = $signed({2'b00, s}) - 34'(d);
    return (a < b) ? a : b;
  endfunction

  logic signed [31:0] gx_q, gx_d, gy_q, gy_d;
  logic [30:0]        hw_q, hw_d, hh_q, hh_d;
  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [31:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic [3:0]         flags_q, flags_d;

  logic [16:0]        dt_q;
  logic [31:0]        sx_q, sy_q;
  logic signed [32:0] dxh_q, dyh_q, dxv_q, dyv_q;
  logic signed [49:0] prod_q;
  logic               hit_h_q, hit_v_q;
  logic signed [33:0] pen_x_q, pen_y_q;

  logic signed [31:0] mul_op;
  logic signed [17:0] dt_s;
  logic signed [31:0] step_inc;
  logic signed [33:0] ov_xh, ov_yh, ov_xv, ov_yv;

  assign dt_s     = $signed({1'b0, dt_q});
  assign step_inc = sat36(36'($signed(prod_q[49:16])));

  assign ov_xh = overlap(sx_q, dxh_q);
  assign ov_yh = overlap(sy_q, dyh_q);
  assign ov_xv = overlap(sx_q, dxv_q);
  assign ov_yv = overlap(sy_q, dyv_q);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_GX:  mul_op = gx_q;
      MUL_GY:  mul_op = gy_q;
      MUL_VX:  mul_op = vel_x_q;
      default: mul_op = vel_y_q;
    endcase
  end

  always_comb begin
    gx_d = gx_q;
    gy_d = gy_q;
    hw_d = hw_q;
    hh_d = hh_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRAVITY_X: gx_d = $signed(cfg_data_i[31:0]);
        CFG_GRAVITY_Y: gy_d = $signed(cfg_data_i[31:0]);
        CFG_HALF_W:    hw_d = cfg_data_i[30:0];
        CFG_HALF_H:    hh_d = cfg_data_i[30:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    vel_x_d = vel_x_q;
    vel_y_d = vel_y_q;
    flags_d = flags_q;
    if (cmd_i.capture) begin
      case (op_i)
        OP_LOAD: begin
          pos_x_d = load_x_i;
          pos_y_d = load_y_i;
          vel_x_d = '0;
          vel_y_d = '0;
          flags_d = '0;
        end
        OP_TICK: flags_d = '0;
        default: begin
        end
      endcase
    end
    if (cmd_i.add_en) begin
      case (cmd_i.add_sel)
        ADD_VX:  vel_x_d = sat36(36'(vel_x_q) + 36'(step_inc));
        ADD_VY:  vel_y_d = sat36(36'(vel_y_q) + 36'(step_inc));
        ADD_PX:  pos_x_d = sat36(36'(pos_x_q) + 36'(step_inc));
        default: pos_y_d = sat36(36'(pos_y_q) + 36'(step_inc));
      endcase
    end
    if (cmd_i.push_en) begin
      if (hit_h_q && vel_x_q[31]) begin
        pos_x_d    = sat36(36'(pos_x_q) + 36'(pen_x_q));
        vel_x_d    = '0;
        flags_d[0] = 1'b1;
      end else if (hit_h_q && vel_x_q != '0) begin
        pos_x_d    = sat36(36'(pos_x_q) - 36'(pen_x_q));
        vel_x_d    = '0;
        flags_d[1] = 1'b1;
      end
      if (hit_v_q && vel_y_q[31]) begin
        pos_y_d    = sat36(36'(pos_y_q) + 36'(pen_y_q));
        vel_y_d    = '0;
        flags_d[2] = 1'b1;
      end else if (hit_v_q && vel_y_q != '0) begin
        pos_y_d    = sat36(36'(pos_y_q) - 36'(pen_y_q));
        vel_y_d    = '0;
        flags_d[3] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q    <= '0;
      gy_q    <= '0;
      hw_q    <= HALF_RESET;
      hh_q    <= HALF_RESET;
      pos_x_q <= '0;
      pos_y_q <= '0;
      vel_x_q <= '0;
      vel_y_q <= '0;
      flags_q <= '0;
    end else begin
      gx_q    <= gx_d;
      gy_q    <= gy_d;
      hw_q    <= hw_d;
      hh_q    <= hh_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      vel_x_q <= vel_x_d;
      vel_y_q <= vel_y_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dt_q  <= delta_t_i;
      sx_q  <= 32'(hw_q) + 32'(other_hw_i);
      sy_q  <= 32'(hh_q) + 32'(other_hh_i);
      dxh_q <= 33'(pos_x_q) - 33'(other_cx_i);
      dyh_q <= 33'(old_y_i) - 33'(other_cy_i);
      dxv_q <= 33'(old_x_i) - 33'(other_cx_i);
      dyv_q <= 33'(pos_y_q) - 33'(other_cy_i);
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_op * dt_s;
    end
    if (cmd_i.ov_en) begin
      hit_h_q <= (ov_xh > 34'sd0) && (ov_yh > 34'sd0);
      hit_v_q <= (ov_xv > 34'sd0) && (ov_yv > 34'sd0);
      pen_x_q <= ov_xh;
      pen_y_q <= ov_yv;
    end
    if (cmd_i.out_load) begin
      body_x_o  <= pos_x_q;
      body_y_o  <= pos_y_q;
      speed_x_o <= vel_x_q;
      speed_y_o <= vel_y_q;
      hits_o    <= flags_q;
    end
  end

endmodule

/* sim/aabb_body_integrate_and_resolve_tb.sv */
// Self-checking testbench for the box body integrator and collision resolver.
// Needs abir_pkg, abir_if and the RTL; predicts each result transaction in the
// testbench and checks it field by field under random stalls on both channels.
module aabb_body_integrate_and_resolve_tb;
  import abir_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic [30:0] HALF_MAX = 31'h7fffffff;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic [16:0]        delta_t;
    logic signed [31:0] other_cx;
    logic signed [31:0] other_cy;
    logic [30:0]        other_hw;
    logic [30:0]        other_hh;
    logic signed [31:0] old_x;
    logic signed [31:0] old_y;
  } body_cmd_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               hit_left;
    logic               hit_right;
    logic               hit_bottom;
    logic               hit_top;
  } body_state_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [31:0] cfg_data;

  abir_in_if  in_ch ();
  abir_out_if out_ch ();

  aabb_body_integrate_and_resolve u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  body_state_t        body;
  logic signed [31:0] grav_x;
  logic signed [31:0] grav_y;
  logic [30:0]        half_w;
  logic [30:0]        half_h;
  logic signed [31:0] tick_from_x;
  logic signed [31:0] tick_from_y;

  body_state_t body_q[$];
  int unsigned mismatches;
  int unsigned cmds_sent;
  bit          send_gaps;
  bit          recv_stalls;
  int unsigned recv_hold;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > S32_MAX) return Q_MAX;
    if (v < S32_MIN) return Q_MIN;
    return v[31:0];
  endfunction

  // Product with the time step, floored to Q16.16 and saturated.
  function automatic logic signed [31:0] scale_dt(input logic signed [31:0] a,
                                                  input logic [16:0] dt);
    longint prod;
    prod = longint'(a) * longint'(dt);
    return sat32(prod >>> 16);
  endfunction

  function automatic longint min64(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic void advance_body(input body_cmd_t c);
    longint px;
    longint py;
    longint ocx;
    longint ocy;
    longint ohw;
    longint ohh;
    longint hw;
    longint hh;
    longint ovx;
    longint ovy;
    hw = half_w;
    hh = half_h;
    ocx = c.other_cx;
    ocy = c.other_cy;
    ohw = c.other_hw;
    ohh = c.other_hh;
    case (c.op)
      OP_LOAD: begin
        body = '{default: '0};
        body.pos_x = c.load_x;
        body.pos_y = c.load_y;
      end
      OP_TICK: begin
        tick_from_x = body.pos_x;
        tick_from_y = body.pos_y;
        body.vel_x = sat32(longint'(body.vel_x) + longint'(scale_dt(grav_x, c.delta_t)));
        body.vel_y = sat32(longint'(body.vel_y) + longint'(scale_dt(grav_y, c.delta_t)));
        body.hit_left = 1'b0;
        body.hit_right = 1'b0;
        body.hit_bottom = 1'b0;
        body.hit_top = 1'b0;
        body.pos_x = sat32(longint'(body.pos_x) + longint'(scale_dt(body.vel_x, c.delta_t)));
        body.pos_y = sat32(longint'(body.pos_y) + longint'(scale_dt(body.vel_y, c.delta_t)));
      end
      OP_RESOLVE: begin
        // The horizontal pass takes the vertical extent at the old y.
        px = body.pos_x;
        py = c.old_y;
        ovx = min64(px + hw - (ocx - ohw), ocx + ohw - (px - hw));
        ovy = min64(py + hh - (ocy - ohh), ocy + ohh - (py - hh));
        if (ovx > 0 && ovy > 0) begin
          if (body.vel_x < 0) begin
            body.pos_x = sat32(px + ovx);
            body.vel_x = '0;
            body.hit_left = 1'b1;
          end else if (body.vel_x > 0) begin
            body.pos_x = sat32(px - ovx);
            body.vel_x = '0;
            body.hit_right = 1'b1;
          end
        end
        // The vertical pass takes the horizontal extent at the old x.
        px = c.old_x;
        py = body.pos_y;
        ovx = min64(px + hw - (ocx - ohw), ocx + ohw - (px - hw));
        ovy = min64(py + hh - (ocy - ohh), ocy + ohh - (py - hh));
        if (ovx > 0 && ovy > 0) begin
          if (body.vel_y < 0) begin
            body.pos_y = sat32(py + ovy);
            body.vel_y = '0;
            body.hit_bottom = 1'b1;
          end else if (body.vel_y > 0) begin
            body.pos_y = sat32(py - ovy);
            body.vel_y = '0;
            body.hit_top = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom;
      default: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
    endcase
  endfunction

  function automatic logic [30:0] rand_half();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return HALF_MAX;
      2: return 31'($urandom);
      default: return 31'($urandom_range(0, 32'h00200000));
    endcase
  endfunction

  function automatic logic [16:0] rand_dt();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      3: return 17'($urandom);
      default: return 17'($urandom_range(1, 65536));
    endcase
  endfunction

  function automatic logic signed [31:0] near(input longint center, input longint span);
    longint reach;
    reach = min64(span, 64'sd1073741824);
    return sat32(center + longint'($urandom_range(32'(2 * reach))) - reach);
  endfunction

  function automatic body_cmd_t noise_cmd();
    body_cmd_t c;
    c.op = 2'($urandom_range(0, 3));
    c.load_x = $urandom;
    c.load_y = $urandom;
    c.delta_t = 17'($urandom);
    c.other_cx = $urandom;
    c.other_cy = $urandom;
    c.other_hw = 31'($urandom);
    c.other_hh = 31'($urandom);
    c.old_x = $urandom;
    c.old_y = $urandom;
    return c;
  endfunction

  function automatic body_cmd_t load_cmd(input logic signed [31:0] x,
                                         input logic signed [31:0] y);
    body_cmd_t c;
    c = noise_cmd();
    c.op = OP_LOAD;
    c.load_x = x;
    c.load_y = y;
    return c;
  endfunction

  function automatic body_cmd_t tick_cmd(input logic [16:0] dt);
    body_cmd_t c;
    c = noise_cmd();
    c.op = OP_TICK;
    c.delta_t = dt;
    return c;
  endfunction

  function automatic body_cmd_t resolve_cmd(input logic signed [31:0] cx,
                                            input logic signed [31:0] cy,
                                            input logic [30:0] hw, input logic [30:0] hh,
                                            input logic signed [31:0] ox,
                                            input logic signed [31:0] oy);
    body_cmd_t c;
    c = noise_cmd();
    c.op = OP_RESOLVE;
    c.other_cx = cx;
    c.other_cy = cy;
    c.other_hw = hw;
    c.other_hh = hh;
    c.old_x = ox;
    c.old_y = oy;
    return c;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_GRAVITY_X: grav_x = data;
      CFG_GRAVITY_Y: grav_y = data;
      CFG_HALF_W:    half_w = data[30:0];
      CFG_HALF_H:    half_h = data[30:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input logic signed [31:0] gx, input logic signed [31:0] gy,
                            input logic [30:0] hw, input logic [30:0] hh);
    write_reg(CFG_GRAVITY_X, gx);
    write_reg(CFG_GRAVITY_Y, gy);
    write_reg(CFG_HALF_W, {1'b0, hw});
    write_reg(CFG_HALF_H, {1'b0, hh});
  endtask

  task automatic send_cmd(input body_cmd_t c);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= c.op;
    in_ch.load_x <= c.load_x;
    in_ch.load_y <= c.load_y;
    in_ch.delta_t <= c.delta_t;
    in_ch.other_cx <= c.other_cx;
    in_ch.other_cy <= c.other_cy;
    in_ch.other_hw <= c.other_hw;
    in_ch.other_hh <= c.other_hh;
    in_ch.old_x <= c.old_x;
    in_ch.old_y <= c.old_y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_body(c);
    body_q.push_back(body);
    if (c.op != OP_NONE) cmds_sent++;
  endtask

  // Waits until every expected result has been seen and the block is idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (body_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Either a single random command, or a load, then ticks, each followed by up to two resolves against nearby boxes.
  task automatic send_sequence();
    body_cmd_t   c;
    logic [30:0] ohw;
    logic [30:0] ohh;
    if ($urandom_range(0, 4) == 0) begin
      send_cmd(noise_cmd());
      return;
    end
    send_cmd(load_cmd(rand_coord(), rand_coord()));
    repeat ($urandom_range(1, 8)) begin
      send_cmd(tick_cmd(rand_dt()));
      repeat ($urandom_range(0, 2)) begin
        ohw = rand_half();
        ohh = rand_half();
        c = resolve_cmd(near(body.pos_x, longint'(half_w) + longint'(ohw)),
                        near(body.pos_y, longint'(half_h) + longint'(ohh)),
                        ohw, ohh, tick_from_x, tick_from_y);
        if ($urandom_range(0, 7) == 0) begin
          c.old_x = rand_coord();
          c.old_y = rand_coord();
        end
        send_cmd(c);
      end
    end
  endtask

  task automatic test_reset_state();
    body_cmd_t c;
    c = noise_cmd();
    c.op = OP_NONE;
    send_cmd(c);
    send_cmd(resolve_cmd('0, '0, 31'd65536, 31'd65536, '0, '0));
    settle();
  endtask

  task automatic test_load_extremes();
    send_cmd(load_cmd(Q_MAX, Q_MIN));
    send_cmd(load_cmd(Q_MIN, Q_MAX));
    send_cmd(load_cmd('0, '0));
    settle();
  endtask

  task automatic test_tick_saturation();
    set_config(Q_MAX, Q_MIN, HALF_RESET, HALF_RESET);
    send_cmd(load_cmd('0, '0));
    send_cmd(tick_cmd(17'd131071));
    send_cmd(tick_cmd(17'd65536));
    send_cmd(tick_cmd('0));
    settle();
    set_config(Q_MIN, Q_MAX, HALF_RESET, HALF_RESET);
    send_cmd(load_cmd(Q_MIN, Q_MAX));
    send_cmd(tick_cmd(17'd1));
    send_cmd(tick_cmd(17'd131071));
    settle();
  endtask

  task automatic test_resolve_pushes();
    // Moving left and up: a box that only touches, then one that overlaps.
    set_config(-32'sd262144, 32'sd262144, HALF_RESET, HALF_RESET);
    send_cmd(load_cmd('0, '0));
    send_cmd(tick_cmd(17'd65536));
    send_cmd(resolve_cmd(-32'sd1048576, 32'sd262144, 31'd262144, 31'd262144, '0, '0));
    send_cmd(resolve_cmd(-32'sd655360, 32'sd262144, 31'd262144, 31'd262144, '0, '0));
    settle();
    // Moving right and down, with a box far away first.
    set_config(32'sd262144, -32'sd262144, HALF_RESET, HALF_RESET);
    send_cmd(load_cmd('0, '0));
    send_cmd(tick_cmd(17'd65536));
    send_cmd(resolve_cmd(32'sd65536000, '0, 31'd262144, 31'd262144, '0, '0));
    send_cmd(resolve_cmd(32'sd655360, -32'sd262144, 31'd262144, 31'd262144, '0, '0));
    settle();
    set_config(Q_MAX, Q_MAX, HALF_MAX, '0);
    send_cmd(load_cmd('0, '0));
    send_cmd(tick_cmd(17'd65536));
    send_cmd(resolve_cmd(Q_MIN, Q_MAX, HALF_MAX, HALF_MAX, Q_MAX, Q_MIN));
    settle();
  endtask

  task automatic test_random_traffic(input logic signed [31:0] gx,
                                     input logic signed [31:0] gy,
                                     input logic [30:0] hw, input logic [30:0] hh,
                                     input int unsigned count);
    int unsigned start;
    set_config(gx, gy, hw, hh);
    start = cmds_sent;
    while (cmds_sent - start < count) send_sequence();
    settle();
  endtask

  task automatic test_backpressure();
    int unsigned start;
    set_config(-32'sd98304, 32'sd642252, HALF_RESET, 31'd262144);
    recv_hold = 80;
    start = cmds_sent;
    while (cmds_sent - start < 40) send_sequence();
    settle();
  endtask

  task automatic test_full_rate();
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    test_random_traffic(32'sd163840, -32'sd642252, 31'd131072, 31'd524288, 100);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (recv_hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (recv_hold) @(posedge clk);
        recv_hold = 0;
      end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    body_state_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (body_q.size() == 0) begin
        $display("%0t: unexpected result transaction: expected none, actual x=%h y=%h",
                 $time, out_ch.body_x, out_ch.body_y);
        mismatches++;
      end else begin
        want = body_q.pop_front();
        check_field("body_x", want.pos_x, out_ch.body_x);
        check_field("body_y", want.pos_y, out_ch.body_y);
        check_field("speed_x", want.vel_x, out_ch.speed_x);
        check_field("speed_y", want.vel_y, out_ch.speed_y);
        check_field("hit_left", 32'(want.hit_left), 32'(out_ch.hit_left));
        check_field("hit_right", 32'(want.hit_right), 32'(out_ch.hit_right));
        check_field("hit_bottom", 32'(want.hit_bottom), 32'(out_ch.hit_bottom));
        check_field("hit_top", 32'(want.hit_top), 32'(out_ch.hit_top));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("aabb_body_integrate_and_resolve_tb failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_GRAVITY_X;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.load_x = '0;
    in_ch.load_y = '0;
    in_ch.delta_t = '0;
    in_ch.other_cx = '0;
    in_ch.other_cy = '0;
    in_ch.other_hw = '0;
    in_ch.other_hh = '0;
    in_ch.old_x = '0;
    in_ch.old_y = '0;
    body = '{default: '0};
    grav_x = '0;
    grav_y = '0;
    half_w = HALF_RESET;
    half_h = HALF_RESET;
    tick_from_x = '0;
    tick_from_y = '0;
    mismatches = 0;
    cmds_sent = 0;
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    recv_hold = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_load_extremes();
    test_tick_saturation();
    test_resolve_pushes();
    test_random_traffic(-32'sd163840, 32'sd642252, HALF_RESET, HALF_RESET, 220);
    test_random_traffic(Q_MAX, Q_MIN, '0, HALF_MAX, 200);
    test_random_traffic(Q_MIN, Q_MAX, HALF_MAX, '0, 200);
    test_random_traffic($urandom_range(0, 32'h001fffff) - 32'h00100000,
                        $urandom_range(0, 32'h001fffff) - 32'h00100000,
                        rand_half(), rand_half(), 220);
    test_random_traffic('0, '0, 31'd65536, 31'd65536, 150);
    test_backpressure();
    test_full_rate();

    if (mismatches == 0) begin
      $display("aabb_body_integrate_and_resolve_tb passed");
    end else begin
      $display("aabb_body_integrate_and_resolve_tb failed");
    end
    $finish;
  end

endmodule
